// ===== rtl/core/sem_pkg.sv =====
`default_nettype none
package sem_pkg;

  localparam int unsigned MaxWidthDef   = 1024;
  localparam int unsigned MaxHeightDef  = 4096;
  localparam int unsigned WidthReset    = 640;
  localparam int unsigned HeightReset   = 480;
  localparam int unsigned PixBits       = 8;
  localparam int unsigned WidthRegBits  = 11;
  localparam int unsigned HeightRegBits = 13;
  localparam int unsigned CfgIdxBits    = 4;
  localparam int unsigned CfgDataBits   = 13;
  localparam int unsigned FifoDepth     = 8;
  // gradient magnitudes stay at or below 4 * 255
  localparam int unsigned MagBits       = 10;
  // floor(x * 683 / 2048) == floor(x / 3) for x up to 1020
  localparam int unsigned Recip3        = 683;
  localparam int unsigned Recip3Shift   = 11;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_WIDTH  = 4'd0,
    CFG_HEIGHT = 4'd1
  } cfg_idx_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    DIV_NONE = 2'd0,
    DIV_BY2  = 2'd1,
    DIV_BY3  = 2'd2,
    DIV_BY4  = 2'd3
  } div_e;

  typedef logic [PixBits-1:0] pix_t;

  // [row][col], row 0 on top, col 0 on the left
  typedef logic [2:0][2:0][PixBits-1:0] win_t;

  // neighbor presence of the output pixel and word control
  typedef struct packed {
    logic emit;
    logic last;
    logic left;
    logic right;
    logic top;
    logic bottom;
  } pos_info_t;

  function automatic logic [31:0] clamp_dim(input logic [31:0] value,
                                            input logic [31:0] limit);
    logic [31:0] res;
    if (value == 32'd0) begin
      res = 32'd1;
    end else if (value > limit) begin
      res = limit;
    end else begin
      res = value;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sem_ram.sv =====
`default_nettype none
module sem_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/sem_ctrl.sv =====
`default_nettype none
module sem_ctrl #(
  parameter int unsigned MaxWidth  = sem_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = sem_pkg::MaxHeightDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              req_type_i,
  input  wire logic [sem_pkg::PixBits-1:0]       pixel_value_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic [sem_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  wire logic [sem_pkg::CfgDataBits-1:0]   cfg_data_i,
  input  wire logic                              pop_i,
  output logic                                   issue_valid_o,
  output logic [$clog2(MaxWidth)-1:0]            issue_addr_o,
  output logic [sem_pkg::PixBits-1:0]            issue_pixel_o,
  output sem_pkg::pos_info_t                     issue_info_o
);
  import sem_pkg::*;

  localparam int unsigned ColBits    = $clog2(MaxWidth);
  localparam int unsigned WBits      = $clog2(MaxWidth + 1);
  localparam int unsigned HBits      = $clog2(MaxHeight + 1);
  localparam int unsigned RowBits    = $clog2(MaxHeight + 2);
  localparam int unsigned OutRowBits = $clog2(MaxHeight);
  localparam int unsigned CredBits   = $clog2(FifoDepth + 1);

  logic [WBits-1:0]      w_q, w_d;
  logic [HBits-1:0]      h_q, h_d;
  logic [ColBits-1:0]    in_col_q, in_col_d;
  logic [RowBits-1:0]    in_row_q, in_row_d;
  logic [ColBits-1:0]    out_col_q, out_col_d;
  logic [OutRowBits-1:0] out_row_q, out_row_d;
  logic [CredBits-1:0]   used_q, used_d;

  logic [WBits-1:0] w_m1;
  logic [HBits-1:0] h_m1;
  logic complete, lagged, credit_ok, accept, silent;
  logic pixel_adv, flush_adv, advance, emit;
  logic in_col_end, out_col_end, out_row_end, restart;

  assign w_m1 = w_q - WBits'(1);
  assign h_m1 = h_q - HBits'(1);

  // the input side runs past the last row while flushing
  assign complete  = in_row_q >= RowBits'(h_q);
  // one row plus one pixel already received
  assign lagged    = (in_row_q >= RowBits'(2)) ||
                     ((in_row_q == RowBits'(1)) && (in_col_q != '0));
  assign credit_ok = used_q < CredBits'(FifoDepth);

  // a one-row frame needs one idle advance before its first flushed word
  assign silent     = complete && !lagged;
  assign in_stall_o = !credit_ok || silent;
  assign accept     = in_valid_i && !in_stall_o;

  assign pixel_adv = accept && !complete && (req_e'(req_type_i) == REQ_PIXEL);
  assign flush_adv = accept && complete;
  assign advance   = silent || pixel_adv || flush_adv;
  assign emit      = (pixel_adv && lagged) || flush_adv;

  assign in_col_end  = in_col_q == ColBits'(w_m1);
  assign out_col_end = out_col_q == ColBits'(w_m1);
  assign out_row_end = out_row_q == OutRowBits'(h_m1);

  always_comb begin
    w_d     = w_q;
    h_d     = h_q;
    restart = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH: begin
          w_d = WBits'(clamp_dim(32'(cfg_data_i[WidthRegBits-1:0]), MaxWidth));
          restart = 1'b1;
        end
        CFG_HEIGHT: begin
          h_d = HBits'(clamp_dim(32'(cfg_data_i[HeightRegBits-1:0]), MaxHeight));
          restart = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (restart || (emit && out_col_end && out_row_end)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else begin
      if (advance) begin
        if (in_col_end) begin
          in_col_d = '0;
          in_row_d = in_row_q + RowBits'(1);
        end else begin
          in_col_d = in_col_q + ColBits'(1);
        end
      end
      if (emit) begin
        if (out_col_end) begin
          out_col_d = '0;
          out_row_d = out_row_q + OutRowBits'(1);
        end else begin
          out_col_d = out_col_q + ColBits'(1);
        end
      end
    end
  end

  // one credit per word in flight or queued at the output
  always_comb begin
    used_d = used_q;
    if (emit && !pop_i) begin
      used_d = used_q + CredBits'(1);
    end else if (!emit && pop_i) begin
      used_d = used_q - CredBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= WBits'(clamp_dim(WidthReset, MaxWidth));
      h_q       <= HBits'(clamp_dim(HeightReset, MaxHeight));
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      used_q    <= '0;
    end else begin
      w_q       <= w_d;
      h_q       <= h_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      used_q    <= used_d;
    end
  end

  assign issue_valid_o       = advance;
  assign issue_addr_o        = in_col_q;
  assign issue_pixel_o       = pixel_value_i;
  assign issue_info_o.emit   = emit;
  assign issue_info_o.last   = out_col_end && out_row_end;
  assign issue_info_o.left   = out_col_q != '0;
  assign issue_info_o.right  = !out_col_end;
  assign issue_info_o.top    = out_row_q != '0;
  assign issue_info_o.bottom = !out_row_end;

endmodule
`default_nettype wire

// ===== rtl/core/sem_window.sv =====
`default_nettype none
module sem_window #(
  parameter int unsigned MaxWidth = sem_pkg::MaxWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          issue_valid_i,
  input  wire logic [$clog2(MaxWidth)-1:0]   issue_addr_i,
  input  wire logic [sem_pkg::PixBits-1:0]   issue_pixel_i,
  input  sem_pkg::pos_info_t                 issue_info_i,
  output logic                               win_valid_o,
  output sem_pkg::pos_info_t                 win_info_o,
  output sem_pkg::win_t                      win_o
);
  import sem_pkg::*;

  localparam int unsigned ColBits  = $clog2(MaxWidth);
  localparam int unsigned WordBits = 2 * PixBits;

  logic                s1_valid_q;
  logic [ColBits-1:0]  s1_addr_q;
  pix_t                s1_pixel_q;
  pos_info_t           s1_info_q;

  logic                fwd_valid_q;
  logic [ColBits-1:0]  fwd_addr_q;
  logic [WordBits-1:0] fwd_data_q;

  logic                s2_valid_q;
  pos_info_t           s2_info_q;
  win_t                win_q;

  logic [WordBits-1:0] ram_rdata, col_word, wr_word;
  pix_t                col_top, col_mid;

  // each word holds the two rows above the incoming one: {older, newer}
  sem_ram #(
    .Width (WordBits),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_word),
    .re_i    (issue_valid_i),
    .raddr_i (issue_addr_i),
    .rdata_o (ram_rdata)
  );

  // a one-pixel row reads back the column written in the cycle before
  assign col_word = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;
  assign col_top  = col_word[WordBits-1:PixBits];
  assign col_mid  = col_word[PixBits-1:0];
  assign wr_word  = {col_mid, s1_pixel_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      s2_valid_q  <= 1'b0;
    end else begin
      s1_valid_q  <= issue_valid_i;
      fwd_valid_q <= s1_valid_q;
      s2_valid_q  <= s1_valid_q && s1_info_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= issue_addr_i;
    s1_pixel_q <= issue_pixel_i;
    s1_info_q  <= issue_info_i;
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= wr_word;
    s2_info_q  <= s1_info_q;
    // shift the window one column left, new column enters on the right
    if (s1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= col_top;
      win_q[1][2] <= col_mid;
      win_q[2][2] <= s1_pixel_q;
    end
  end

  assign win_valid_o = s2_valid_q;
  assign win_info_o  = s2_info_q;
  assign win_o       = win_q;

endmodule
`default_nettype wire

// ===== rtl/core/sem_grad.sv =====
`default_nettype none
module sem_grad (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        win_valid_i,
  input  sem_pkg::pos_info_t               win_info_i,
  input  sem_pkg::win_t                    win_i,
  output logic                             push_valid_o,
  output logic [sem_pkg::PixBits-1:0]      push_edge_o,
  output logic                             push_last_o
);
  import sem_pkg::*;

  win_t               px;
  logic [2:0]         row_ok, col_ok;
  logic [MagBits-1:0] a_pos, a_neg, b_pos, b_neg, a_abs, b_abs;
  div_e               a_div, b_div;

  logic               sa_valid_q;
  logic               sa_last_q;
  logic [MagBits-1:0] a_abs_q, b_abs_q;
  div_e               a_div_q, b_div_q;

  logic [MagBits-1:0] a_quo, b_quo, half;
  logic [MagBits:0]   mag_sum;
  pix_t               edge_val;

  logic               push_valid_q;
  pix_t               push_edge_q;
  logic               push_last_q;

  function automatic logic [MagBits-1:0] tri_sum(input pix_t p0, input pix_t p1,
                                                 input pix_t p2);
    return MagBits'(p0) + (MagBits'(p1) << 1) + MagBits'(p2);
  endfunction

  function automatic logic [MagBits-1:0] abs_diff(input logic [MagBits-1:0] x,
                                                  input logic [MagBits-1:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

  // weight sum of a side is 2 plus the two corners present on that side
  function automatic div_e pick_div(input logic near, input logic far,
                                    input logic side0, input logic side1);
    div_e code;
    if (!(near ^ far)) begin
      code = DIV_NONE;
    end else if (side0 && side1) begin
      code = DIV_BY4;
    end else if (side0 || side1) begin
      code = DIV_BY3;
    end else begin
      code = DIV_BY2;
    end
    return code;
  endfunction

  function automatic logic [MagBits-1:0] div_small(input logic [MagBits-1:0] x,
                                                   input div_e code);
    logic [2*MagBits-1:0] prod;
    logic [MagBits-1:0]   res;
    prod = (2 * MagBits)'(x) * (2 * MagBits)'(Recip3);
    unique case (code)
      DIV_NONE: res = x;
      DIV_BY2:  res = x >> 1;
      DIV_BY3:  res = MagBits'(prod >> Recip3Shift);
      DIV_BY4:  res = x >> 2;
      default:  res = x;
    endcase
    return res;
  endfunction

  assign row_ok = {win_info_i.bottom, 1'b1, win_info_i.top};
  assign col_ok = {win_info_i.right, 1'b1, win_info_i.left};

  // zero the neighbors outside the frame
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        px[r][c] = (row_ok[r] && col_ok[c]) ? win_i[r][c] : '0;
      end
    end
  end

  assign a_pos = tri_sum(px[2][0], px[2][1], px[2][2]);
  assign a_neg = tri_sum(px[0][0], px[0][1], px[0][2]);
  assign b_pos = tri_sum(px[0][2], px[1][2], px[2][2]);
  assign b_neg = tri_sum(px[0][0], px[1][0], px[2][0]);
  assign a_abs = abs_diff(a_pos, a_neg);
  assign b_abs = abs_diff(b_pos, b_neg);
  assign a_div = pick_div(win_info_i.top, win_info_i.bottom,
                          win_info_i.left, win_info_i.right);
  assign b_div = pick_div(win_info_i.left, win_info_i.right,
                          win_info_i.top, win_info_i.bottom);

  assign a_quo    = div_small(a_abs_q, a_div_q);
  assign b_quo    = div_small(b_abs_q, b_div_q);
  assign mag_sum  = {1'b0, a_quo} + {1'b0, b_quo};
  assign half     = mag_sum[MagBits:1];
  assign edge_val = (|half[MagBits-1:PixBits]) ? '1 : half[PixBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_valid_q   <= 1'b0;
      push_valid_q <= 1'b0;
    end else begin
      sa_valid_q   <= win_valid_i;
      push_valid_q <= sa_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_last_q   <= win_info_i.last;
    a_abs_q     <= a_abs;
    b_abs_q     <= b_abs;
    a_div_q     <= a_div;
    b_div_q     <= b_div;
    push_edge_q <= edge_val;
    push_last_q <= sa_last_q;
  end

  assign push_valid_o = push_valid_q;
  assign push_edge_o  = push_edge_q;
  assign push_last_o  = push_last_q;

endmodule
`default_nettype wire

// ===== rtl/core/sem_ofifo.sv =====
`default_nettype none
module sem_ofifo (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire logic [sem_pkg::PixBits-1:0] push_edge_i,
  input  wire logic                        push_last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [sem_pkg::PixBits-1:0]      edge_value_o,
  output logic                             frame_last_o,
  output logic                             pop_o
);
  import sem_pkg::*;

  localparam int unsigned PtrBits = $clog2(FifoDepth);
  localparam int unsigned CntBits = $clog2(FifoDepth + 1);

  logic [PixBits:0]   entry_q [FifoDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               pop;

  assign out_valid_o  = count_q != '0;
  assign pop          = out_valid_o && !out_stall_i;
  assign edge_value_o = entry_q[rd_ptr_q][PixBits-1:0];
  assign frame_last_o = entry_q[rd_ptr_q][PixBits];
  assign pop_o        = pop;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + CntBits'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= {push_last_i, push_edge_i};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sobel_edge_magnitude_3x3_top.sv =====
`default_nettype none
// Streaming 3x3 Sobel edge magnitude over an 8-bit grayscale frame sent in raster
// order. One pixel word is taken per clock while the output side keeps up; each
// word gives the edge value of the pixel one row plus one pixel earlier, and one
// flush word per pending pixel drains the tail of the frame, the last result
// carrying frame_last. A one-row frame holds its first flush for an idle advance.
// Results are registered in the window, the gradient stages and the output queue.
// The rate is set by the single line RAM (MaxWidth words of two pixels), read and
// written back once per pixel, and by an eight-word output queue whose credits
// stall the input when the consumer stalls. Border pixels divide each sum by its
// weight sum (2, 3 or 4), no RAM clearing is needed after reset, and a configuration
// write (to be made only while idle) to the width or height restarts the frame.
module sobel_edge_magnitude_3x3_top #(
  parameter int unsigned MaxWidth  = sem_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = sem_pkg::MaxHeightDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            req_type_i,
  input  wire logic [sem_pkg::PixBits-1:0]     pixel_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [sem_pkg::PixBits-1:0]          edge_value_o,
  output logic                                 frame_last_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [sem_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [sem_pkg::CfgDataBits-1:0] cfg_data_i
);
  import sem_pkg::*;

  localparam int unsigned ColBits = $clog2(MaxWidth);

  logic               issue_valid;
  logic [ColBits-1:0] issue_addr;
  pix_t               issue_pixel;
  pos_info_t          issue_info;
  logic               win_valid;
  pos_info_t          win_info;
  win_t               win;
  logic               push_valid;
  pix_t               push_edge;
  logic               push_last;
  logic               pop;

  assign cfg_ready_o = 1'b1;

  sem_ctrl #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .pixel_value_i (pixel_value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pop_i         (pop),
    .issue_valid_o (issue_valid),
    .issue_addr_o  (issue_addr),
    .issue_pixel_o (issue_pixel),
    .issue_info_o  (issue_info)
  );

  sem_window #(
    .MaxWidth (MaxWidth)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_valid_i (issue_valid),
    .issue_addr_i  (issue_addr),
    .issue_pixel_i (issue_pixel),
    .issue_info_i  (issue_info),
    .win_valid_o   (win_valid),
    .win_info_o    (win_info),
    .win_o         (win)
  );

  sem_grad u_grad (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .win_valid_i  (win_valid),
    .win_info_i   (win_info),
    .win_i        (win),
    .push_valid_o (push_valid),
    .push_edge_o  (push_edge),
    .push_last_o  (push_last)
  );

  sem_ofifo u_ofifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_edge_i  (push_edge),
    .push_last_i  (push_last),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .edge_value_o (edge_value_o),
    .frame_last_o (frame_last_o),
    .pop_o        (pop)
  );

endmodule
`default_nettype wire

// ===== verif/sobel_edge_checker.sv =====
module sobel_edge_checker
  import sem_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   req_type_i,
  input  pix_t                   pixel_value_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  pix_t                   edge_value_i,
  input  logic                   frame_last_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output int                     mismatch_count_o = 0,
  output int                     results_pending_o = 0
);

  localparam int unsigned RingDepth = 2 * MaxWidthDef + 3;

  typedef struct packed {
    pix_t edge_value;
    logic frame_last;
  } edge_word_t;

  pix_t                     pixel_ring [RingDepth];
  edge_word_t               edges_due [$];
  logic [WidthRegBits-1:0]  width_reg  = WidthRegBits'(WidthReset);
  logic [HeightRegBits-1:0] height_reg = HeightRegBits'(HeightReset);
  int unsigned              col_next = 0;
  int unsigned              row_next = 0;
  int unsigned              edge_next = 0;
  int                       errors = 0;

  initial begin
    foreach (pixel_ring[i]) pixel_ring[i] = '0;
  end

  function automatic int unsigned active_width();
    if (width_reg == '0) return 1;
    if (width_reg > MaxWidthDef) return MaxWidthDef;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == '0) return 1;
    if (height_reg > MaxHeightDef) return MaxHeightDef;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    col_next  = 0;
    row_next  = 0;
    edge_next = 0;
  endfunction

  // Border pixels divide each sum by the weights that fell inside the frame.
  function automatic pix_t sobel_magnitude(int unsigned pos, int unsigned w, int unsigned h);
    int          ox, oy, nx, ny, pv, wa, wb;
    int          sum_a, sum_b, wsum_a, wsum_b, mag;
    int unsigned lin;
    ox = int'(pos % w);
    oy = int'(pos / w);
    sum_a = 0;
    sum_b = 0;
    wsum_a = 0;
    wsum_b = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        nx = ox + dx;
        ny = oy + dy;
        if (nx >= 0 && ny >= 0 && nx < int'(w) && ny < int'(h)) begin
          lin = (unsigned'(ny) * w + unsigned'(nx)) % RingDepth;
          pv = int'(pixel_ring[lin]);
          wa = dy * ((dx == 0) ? 2 : 1);
          wb = dx * ((dy == 0) ? 2 : 1);
          sum_a += pv * wa;
          sum_b += pv * wb;
          wsum_a += wa;
          wsum_b += wb;
        end
      end
    end
    if (wsum_a != 0) sum_a = sum_a / wsum_a;
    if (wsum_b != 0) sum_b = sum_b / wsum_b;
    if (sum_a < 0) sum_a = -sum_a;
    if (sum_b < 0) sum_b = -sum_b;
    mag = (sum_a + sum_b) / 2;
    return (mag > 255) ? '1 : pix_t'(mag);
  endfunction

  task automatic absorb_word(logic kind, pix_t value);
    int unsigned w, h, total, in_count, pos;
    logic        complete, emit;
    w = active_width();
    h = active_height();
    total = w * h;
    complete = (row_next >= h);
    in_count = complete ? total : row_next * w + col_next;
    emit = 1'b0;
    pos = edge_next;
    if (kind == REQ_PIXEL && !complete) begin
      pixel_ring[in_count % RingDepth] = value;
      col_next++;
      if (col_next >= w) begin
        col_next = 0;
        row_next++;
      end
      in_count++;
      if (in_count > edge_next + w + 1) emit = 1'b1;
    end else if (complete && edge_next < total) begin
      // a pixel past the frame's end drains like a flush
      emit = 1'b1;
    end
    if (emit) begin
      edges_due.push_back('{edge_value: sobel_magnitude(pos, w, h),
                            frame_last: (pos == total - 1)});
      edge_next++;
      if (pos == total - 1) restart_frame();
    end
  endtask

  always @(posedge clk_i) begin
    edge_word_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_WIDTH) begin
          width_reg = cfg_data_i[WidthRegBits-1:0];
          restart_frame();
        end else if (cfg_index_i == CFG_HEIGHT) begin
          height_reg = cfg_data_i[HeightRegBits-1:0];
          restart_frame();
        end
      end
      if (in_valid_i && !in_stall_i) absorb_word(req_type_i, pixel_value_i);
      if (out_valid_i && !out_stall_i) begin
        if (edges_due.size() == 0) begin
          $error("unexpected result word: edge_value %0d frame_last %0d",
                 edge_value_i, frame_last_i);
          errors++;
        end else begin
          want = edges_due.pop_front();
          if (edge_value_i !== want.edge_value) begin
            $error("edge_value: expected %0d, actual %0d", want.edge_value, edge_value_i);
            errors++;
          end
          if (frame_last_i !== want.frame_last) begin
            $error("frame_last: expected %0d, actual %0d", want.frame_last, frame_last_i);
            errors++;
          end
        end
      end
      mismatch_count_o <= errors;
      results_pending_o <= edges_due.size();
    end
  end

endmodule

// ===== verif/tb_sobel_edge_magnitude_3x3_top.sv =====
module tb_sobel_edge_magnitude_3x3_top;
  import sem_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int LongHold   = 400;
  localparam int DrainPause = 16;
  localparam int PhaseItems = 460;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  req_e                   req_type = REQ_PIXEL;
  pix_t                   pixel_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  pix_t                   edge_value;
  logic                   frame_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  int          mismatch_count;
  int          results_pending;
  int unsigned frame_w = WidthReset;
  int unsigned frame_h = HeightReset;
  int          words_sent = 0;

  sobel_edge_magnitude_3x3_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .pixel_value_i (pixel_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .edge_value_o  (edge_value),
    .frame_last_o  (frame_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  sobel_edge_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .req_type_i        (req_type),
    .pixel_value_i     (pixel_value),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .edge_value_i      (edge_value),
    .frame_last_i      (frame_last),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver: random stalls, or one long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LongHold;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("sobel_edge_magnitude_3x3_top: mismatch");
    $finish;
  end

  task automatic push_word(req_e kind, pix_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    pixel_value <= value;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    // first let the word just taken show up in the pending count
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] index, logic [CfgDataBits-1:0] value);
    wait_drained();
    // let a word that yields no result clear the pipeline
    repeat (DrainPause) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (index == CFG_WIDTH) begin
      frame_w = value[WidthRegBits-1:0];
      if (frame_w == 0) frame_w = 1;
      if (frame_w > MaxWidthDef) frame_w = MaxWidthDef;
    end else if (index == CFG_HEIGHT) begin
      frame_h = value[HeightRegBits-1:0];
      if (frame_h == 0) frame_h = 1;
      if (frame_h > MaxHeightDef) frame_h = MaxHeightDef;
    end
  endtask

  function automatic pix_t frame_pixel(int style, int unsigned x, int unsigned y,
                                       pix_t lo, pix_t hi);
    case (style)
      0: return pix_t'($urandom);
      1: return ($urandom_range(1) != 0) ? '1 : '0;
      2: return (x < frame_w / 2) ? lo : hi;
      default: return (y % 2 != 0) ? hi : (lo ^ pix_t'($urandom_range(7)));
    endcase
  endfunction

  task automatic send_frame(int style, bit drain_midway);
    int unsigned total, tail;
    pix_t        lo, hi;
    total = frame_w * frame_h;
    lo = pix_t'($urandom);
    hi = pix_t'($urandom);
    for (int unsigned p = 0; p < total; p++) begin
      // flush inside the frame: dropped
      if ($urandom_range(99) < 4) push_word(REQ_FLUSH, pix_t'($urandom));
      if (drain_midway && p == total / 2) wait_drained();
      push_word(REQ_PIXEL, frame_pixel(style, p % frame_w, p / frame_w, lo, hi));
      words_sent++;
    end
    tail = (total < frame_w + 1) ? total : frame_w + 1;
    repeat (tail) begin
      if ($urandom_range(3) == 0)
        push_word(REQ_PIXEL, pix_t'($urandom));
      else
        push_word(REQ_FLUSH, pix_t'($urandom));
      words_sent++;
    end
    // nothing pending any more
    if ($urandom_range(3) == 0) push_word(REQ_FLUSH, pix_t'($urandom));
  endtask

  task automatic pick_frame();
    if ($urandom_range(5) == 0)
      write_reg(CfgIdxBits'($urandom_range(2 ** CfgIdxBits - 1, CFG_HEIGHT + 1)),
                CfgDataBits'($urandom));
    if ($urandom_range(3) != 0)
      write_reg(CFG_WIDTH, CfgDataBits'(($urandom_range(9) == 0) ? $urandom_range(40, 9)
                                                                 : $urandom_range(8, 0)));
    if ($urandom_range(3) != 0)
      write_reg(CFG_HEIGHT, CfgDataBits'($urandom_range(6, 0)));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct <= 34;
    recv_idle_pct <= 69;

    // checkerboard of extremes in a 3x2 frame
    write_reg(CFG_WIDTH, 3);
    write_reg(CFG_HEIGHT, 2);
    push_word(REQ_FLUSH, '1);
    push_word(REQ_PIXEL, '0);
    push_word(REQ_PIXEL, '1);
    push_word(REQ_PIXEL, '0);
    push_word(REQ_PIXEL, '1);
    push_word(REQ_PIXEL, '0);
    push_word(REQ_PIXEL, '1);
    push_word(REQ_FLUSH, '0);
    push_word(REQ_PIXEL, '1);
    push_word(REQ_FLUSH, '0);
    push_word(REQ_FLUSH, '0);
    push_word(REQ_FLUSH, '0);
    // zero sizes act as one: single pixel frame
    write_reg(CFG_WIDTH, '0);
    write_reg(CFG_HEIGHT, '0);
    push_word(REQ_PIXEL, '1);
    push_word(REQ_FLUSH, '0);
    // one-row frame
    write_reg(CFG_WIDTH, 4);
    write_reg(CFG_HEIGHT, 1);
    push_word(REQ_PIXEL, '1);
    push_word(REQ_PIXEL, '0);
    push_word(REQ_PIXEL, '1);
    push_word(REQ_PIXEL, '1);
    repeat (4) push_word(REQ_FLUSH, '0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct <= 34;
          recv_idle_pct <= 69;
        end
        1: begin
          send_idle_pct <= 69;
          recv_idle_pct <= 34;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      words_sent = 0;
      if (phase == 0) begin
        // hold the output off while pixels keep coming
        write_reg(CFG_WIDTH, 20);
        write_reg(CFG_HEIGHT, 6);
        hold_toggle <= ~hold_toggle;
        send_frame(0, 1'b0);
      end else if (phase == 1) begin
        write_reg(CFG_WIDTH, 12);
        write_reg(CFG_HEIGHT, 5);
        send_frame(1, 1'b1);
      end
      while (words_sent < PhaseItems) begin
        pick_frame();
        send_frame($urandom_range(3), ($urandom_range(9) == 0));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("sobel_edge_magnitude_3x3_top: match");
    end else begin
      $display("sobel_edge_magnitude_3x3_top: mismatch");
    end
    $finish;
  end

endmodule
